// ===== sv/rro_pkg.sv =====
// Package: shared types, constants and state codes for the rectangle overlap checker.
`timescale 1ns / 1ps
package rro_pkg;
  localparam int MaxRects   = 256;
  localparam int CoordBits  = 25;
  localparam int RowBits    = 8;
  localparam int CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegThetaStep = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegPhiStep   = 1'd1;

  typedef enum logic [12:0] {
    S_LOAD    = 13'b0000000000001,
    S_INS_I   = 13'b0000000000010,
    S_INS_IW  = 13'b0000000000100,
    S_INS_J   = 13'b0000000001000,
    S_INS_PW  = 13'b0000000010000,
    S_INS_CMP = 13'b0000000100000,
    S_CHK_A   = 13'b0000001000000,
    S_CHK_AW1 = 13'b0000010000000,
    S_CHK_AW2 = 13'b0000100000000,
    S_CHK_B   = 13'b0001000000000,
    S_CHK_BW  = 13'b0010000000000,
    S_CHK_CMP = 13'b0100000000000,
    S_POST    = 13'b1000000000000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic store_in;     // write incoming rectangle at count
    logic ins_start;    // i := 0
    logic ins_fetch;    // read rect i, j := i
    logic lat_cur;      // capture rect i as the one to insert
    logic rd_prev;      // read order[j-1]
    logic cap_idx;      // capture the order entry just read
    logic ins_shift;    // order[j] := order[j-1], j--
    logic ins_place;    // order[j] := i, i++
    logic chk_start;    // j := 0
    logic lat_a;        // latch rect a, k := j+1
    logic rd_b;         // read order[k]
    logic next_b;       // k++
    logic next_a;       // j++
    logic set_fail;
    logic set_pass;
    logic publish;      // move verdict to output, clear the set
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic ins_done;     // i == n
    logic j_zero;
    logic cur_before;   // cur sorts before order[j-1] rect
    logic a_done;       // j+1 >= n
    logic b_done;       // k >= n
    logic pair_fail;
    logic pair_stop;
  } dp_stat_t;
endpackage

// ===== sv/rro_if.sv =====
// Interfaces: valid/ready request channels for rectangles and results.
`timescale 1ns / 1ps
interface rro_in_if #(parameter int CoordBits = rro_pkg::CoordBits);
  logic valid;
  logic ready;
  logic [CoordBits-1:0] theta_lower;
  logic [CoordBits-1:0] theta_upper;
  logic [CoordBits-1:0] phi_lower;
  logic [CoordBits-1:0] phi_upper;
  logic last_rect;
  modport source (output valid, theta_lower, theta_upper, phi_lower, phi_upper, last_rect,
                  input ready);
  modport sink (input valid, theta_lower, theta_upper, phi_lower, phi_upper, last_rect,
                output ready);
endinterface

interface rro_out_if;
  logic valid;
  logic ready;
  logic pass;
  logic [rro_pkg::RowBits-1:0] first_row;
  logic [rro_pkg::RowBits-1:0] second_row;
  logic overflow;
  modport source (output valid, pass, first_row, second_row, overflow, input ready);
  modport sink (input valid, pass, first_row, second_row, overflow, output ready);
endinterface

// ===== sv/rro_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module rro_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/rro_datapath.sv =====
// Datapath: rectangle and order memories, index counters, compare and check logic.
`timescale 1ns / 1ps
module rro_datapath #(
  parameter int MaxRects  = rro_pkg::MaxRects,
  parameter int CoordBits = rro_pkg::CoordBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rro_pkg::dp_cmd_t     cmd,
  output rro_pkg::dp_stat_t    stat,
  input  logic [CoordBits-1:0] in_tl,
  input  logic [CoordBits-1:0] in_tu,
  input  logic [CoordBits-1:0] in_pl,
  input  logic [CoordBits-1:0] in_pu,
  input  logic [CoordBits-1:0] theta_nudge,
  input  logic [CoordBits-1:0] phi_nudge,
  output logic                 res_pass,
  output logic [rro_pkg::RowBits-1:0] res_first,
  output logic [rro_pkg::RowBits-1:0] res_second,
  output logic                 res_ovf
);
  localparam int IdxBits = $clog2(MaxRects);
  localparam int CntBits = $clog2(MaxRects + 1);
  localparam int RectBits = 4 * CoordBits;

  logic [CntBits-1:0] count, i, j, k;
  logic               ovf;
  logic [CoordBits-1:0] cur_tl, cur_tu, cur_pl, cur_pu;
  logic [CoordBits-1:0] a_tu, a_pu;
  logic [IdxBits-1:0]   a_idx, got_idx;
  logic                 vd_pass;
  logic [IdxBits-1:0]   vd_first, vd_second;

  logic               rect_we;
  logic [IdxBits-1:0] rect_raddr;
  logic [RectBits-1:0] rect_rd;
  logic               ord_we;
  logic [IdxBits-1:0] ord_waddr, ord_raddr;
  logic [IdxBits-1:0] ord_wdata, ord_rd;
  logic [CoordBits-1:0] r_tl, r_tu, r_pl, r_pu;
  logic cur_first;
  logic [CoordBits:0] t_sum, p_sum;
  logic fail_c, stop_c;

  assign rect_we = cmd.store_in && !stat.full;

  rro_ram #(.Width(RectBits), .Depth(MaxRects)) u_rect (
    .clk, .we(rect_we), .waddr(count[IdxBits-1:0]),
    .wdata({in_tl, in_tu, in_pl, in_pu}), .raddr(rect_raddr), .rdata(rect_rd));

  rro_ram #(.Width(IdxBits), .Depth(MaxRects)) u_ord (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rd));

  assign {r_tl, r_tu, r_pl, r_pu} = rect_rd;

  // order read: j-1 during insertion, k for b, j otherwise
  always_comb begin
    if (cmd.rd_prev)   ord_raddr = IdxBits'(j - 1'b1);
    else if (cmd.rd_b) ord_raddr = k[IdxBits-1:0];
    else               ord_raddr = j[IdxBits-1:0];
  end
  // rect read: rect i when fetching an insert, else the order entry just read
  assign rect_raddr = cmd.ins_fetch ? i[IdxBits-1:0] : ord_rd;

  assign ord_we    = cmd.ins_shift || cmd.ins_place;
  assign ord_waddr = j[IdxBits-1:0];
  assign ord_wdata = cmd.ins_shift ? got_idx : i[IdxBits-1:0];

  // sort compare: cur before prev rect (r_*), ties by lower index
  always_comb begin
    if (cur_tl != r_tl)      cur_first = cur_tl < r_tl;
    else if (cur_tu != r_tu) cur_first = cur_tu < r_tu;
    else if (cur_pl != r_pl) cur_first = cur_pl < r_pl;
    else if (cur_pu != r_pu) cur_first = cur_pu < r_pu;
    else                     cur_first = i[IdxBits-1:0] < got_idx;
  end

  // pair check, a in a_*, b in r_*
  assign t_sum = {1'b0, r_tl} + {1'b0, theta_nudge};
  assign p_sum = {1'b0, r_pl} + {1'b0, phi_nudge};
  always_comb begin
    fail_c = 1'b0;
    stop_c = 1'b0;
    if (a_tu == r_tl) begin
      fail_c = (a_pu >= r_pl) && (t_sum > {1'b0, r_tu});
    end else if (a_tu > r_tl) begin
      if (a_pu == r_pl) fail_c = p_sum > {1'b0, r_pu};
      else              fail_c = a_pu > r_pl;
    end else begin
      stop_c = 1'b1;
    end
  end

  assign stat.full       = count == CntBits'(MaxRects);
  assign stat.ins_done   = i == count;
  assign stat.j_zero     = j == '0;
  assign stat.cur_before = cur_first;
  assign stat.a_done     = (j + 1'b1) >= count;
  assign stat.b_done     = k >= count;
  assign stat.pair_fail  = fail_c;
  assign stat.pair_stop  = stop_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.publish) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.store_in) begin
      if (stat.full) ovf <= 1'b1;
      else           count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_start)      i <= '0;
    else if (cmd.ins_place) i <= i + 1'b1;

    if (cmd.ins_fetch)      j <= i;
    else if (cmd.ins_shift) j <= j - 1'b1;
    else if (cmd.chk_start) j <= '0;
    else if (cmd.next_a)    j <= j + 1'b1;

    if (cmd.lat_a)       k <= j + 1'b1;
    else if (cmd.next_b) k <= k + 1'b1;

    if (cmd.lat_cur) begin
      cur_tl <= r_tl; cur_tu <= r_tu; cur_pl <= r_pl; cur_pu <= r_pu;
    end
    if (cmd.cap_idx) got_idx <= ord_rd;
    if (cmd.lat_a) begin
      a_tu  <= r_tu;
      a_pu  <= r_pu;
      a_idx <= got_idx;
    end

    if (cmd.set_fail) begin
      vd_pass   <= 1'b0;
      vd_first  <= a_idx;
      vd_second <= got_idx;
    end else if (cmd.set_pass) begin
      vd_pass   <= 1'b1;
      vd_first  <= '0;
      vd_second <= '0;
    end

    if (cmd.publish) begin
      res_pass   <= vd_pass;
      res_first  <= rro_pkg::RowBits'(vd_first);
      res_second <= rro_pkg::RowBits'(vd_second);
      res_ovf    <= ovf;
    end
  end
endmodule

// ===== sv/rro_ctrl.sv =====
// Controller: load, insertion sort and pair scan sequencing.
`timescale 1ns / 1ps
module rro_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output rro_pkg::dp_cmd_t  cmd,
  input  rro_pkg::dp_stat_t stat
);
  rro_pkg::state_t state, state_next;
  logic res_held, res_held_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rro_pkg::S_LOAD;
      res_held <= 1'b0;
    end else begin
      state    <= state_next;
      res_held <= res_held_next;
    end
  end

  assign in_ready  = state == rro_pkg::S_LOAD;
  assign out_valid = res_held;

  always_comb begin
    state_next = state;
    res_held_next = res_held && !out_ready;
    cmd = '0;
    case (state)
      rro_pkg::S_LOAD: begin
        if (in_valid) begin
          cmd.store_in = 1'b1;
          if (in_last) begin
            cmd.ins_start = 1'b1;
            state_next = rro_pkg::S_INS_I;
          end
        end
      end
      rro_pkg::S_INS_I: begin
        if (stat.ins_done) begin
          cmd.chk_start = 1'b1;
          state_next = rro_pkg::S_CHK_A;
        end else begin
          cmd.ins_fetch = 1'b1;
          state_next = rro_pkg::S_INS_IW;
        end
      end
      rro_pkg::S_INS_IW: begin
        cmd.lat_cur = 1'b1;
        state_next = rro_pkg::S_INS_J;
      end
      rro_pkg::S_INS_J: begin
        if (stat.j_zero) begin
          cmd.ins_place = 1'b1;
          state_next = rro_pkg::S_INS_I;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next = rro_pkg::S_INS_PW;
        end
      end
      rro_pkg::S_INS_PW: begin
        cmd.cap_idx = 1'b1;
        state_next = rro_pkg::S_INS_CMP;
      end
      rro_pkg::S_INS_CMP: begin
        if (stat.cur_before) begin
          cmd.ins_shift = 1'b1;
          state_next = rro_pkg::S_INS_J;
        end else begin
          cmd.ins_place = 1'b1;
          state_next = rro_pkg::S_INS_I;
        end
      end
      rro_pkg::S_CHK_A: begin
        if (stat.a_done) begin
          cmd.set_pass = 1'b1;
          state_next = rro_pkg::S_POST;
        end else begin
          state_next = rro_pkg::S_CHK_AW1;
        end
      end
      rro_pkg::S_CHK_AW1: begin
        cmd.cap_idx = 1'b1;
        state_next = rro_pkg::S_CHK_AW2;
      end
      rro_pkg::S_CHK_AW2: begin
        cmd.lat_a = 1'b1;
        state_next = rro_pkg::S_CHK_B;
      end
      rro_pkg::S_CHK_B: begin
        if (stat.b_done) begin
          cmd.next_a = 1'b1;
          state_next = rro_pkg::S_CHK_A;
        end else begin
          cmd.rd_b = 1'b1;
          state_next = rro_pkg::S_CHK_BW;
        end
      end
      rro_pkg::S_CHK_BW: begin
        cmd.cap_idx = 1'b1;
        state_next = rro_pkg::S_CHK_CMP;
      end
      rro_pkg::S_CHK_CMP: begin
        if (stat.pair_fail) begin
          cmd.set_fail = 1'b1;
          state_next = rro_pkg::S_POST;
        end else if (stat.pair_stop) begin
          cmd.next_a = 1'b1;
          state_next = rro_pkg::S_CHK_A;
        end else begin
          cmd.next_b = 1'b1;
          state_next = rro_pkg::S_CHK_B;
        end
      end
      rro_pkg::S_POST: begin
        // wait for the output register to free up
        if (!res_held || out_ready) begin
          cmd.publish = 1'b1;
          res_held_next = 1'b1;
          state_next = rro_pkg::S_LOAD;
        end
      end
      default: state_next = rro_pkg::S_LOAD;
    endcase
  end
endmodule

// ===== sv/rect_region_overlap_check.sv =====
// Top level: angular rectangle overlap checker.
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | theta/phi bounds, last_rect
//   res     | out | valid/ready   | pass, first_row, second_row, overflow
//   cfg     | in  | cfg_we        | cfg_index, cfg_data
// Loading accepts one request per cycle; ready drops after the last_rect request.
// Sort: fetch each rectangle (S_INS_I, S_INS_IW), then compare it against earlier
// entries (S_INS_J, S_INS_PW, S_INS_CMP) until it is placed. Scan: per row a
// S_CHK_A to S_CHK_AW2, per pair S_CHK_B to S_CHK_CMP; S_POST posts the result.
// The result waits in an output register while the next set loads; a check
// that finishes before it is taken stalls. Synchronous active-high reset.
`timescale 1ns / 1ps
module rect_region_overlap_check #(
  parameter int MaxRects  = rro_pkg::MaxRects,
  parameter int CoordBits = rro_pkg::CoordBits
) (
  input  logic clk,
  input  logic rst,
  rro_in_if.sink    req,
  rro_out_if.source res,
  input  logic                            cfg_we,
  input  logic [rro_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [CoordBits-1:0]            cfg_data
);
  logic [CoordBits-1:0] theta_nudge, phi_nudge;
  rro_pkg::dp_cmd_t  cmd;
  rro_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      theta_nudge <= '0;
      phi_nudge   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rro_pkg::RegThetaStep: theta_nudge <= cfg_data;
        rro_pkg::RegPhiStep:   phi_nudge   <= cfg_data;
        default: ;
      endcase
    end
  end

  rro_ctrl u_ctrl (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready), .in_last(req.last_rect),
    .out_valid(res.valid), .out_ready(res.ready), .cmd, .stat);

  rro_datapath #(.MaxRects(MaxRects), .CoordBits(CoordBits)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_tl(req.theta_lower), .in_tu(req.theta_upper),
    .in_pl(req.phi_lower), .in_pu(req.phi_upper),
    .theta_nudge, .phi_nudge,
    .res_pass(res.pass), .res_first(res.first_row),
    .res_second(res.second_row), .res_ovf(res.overflow));

`ifndef SYNTH
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid) else $error("result dropped");
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=>
      $stable({res.pass, res.first_row, res.second_row, res.overflow}))
    else $error("result changed while waiting");
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.last_rect |=> !req.ready)
    else $error("request taken during check");
`endif
endmodule

// ===== bench/tb_rro_if.sv =====
// Testbench copy note: interfaces come from the RTL; this file holds bench-side request and verdict types.
`timescale 1ns / 1ps
package tb_rro_types;
  typedef struct packed {
    logic [rro_pkg::CoordBits-1:0] tl;
    logic [rro_pkg::CoordBits-1:0] tu;
    logic [rro_pkg::CoordBits-1:0] pl;
    logic [rro_pkg::CoordBits-1:0] pu;
    logic last;
  } rect_req_t;

  typedef struct packed {
    logic pass;
    logic [rro_pkg::RowBits-1:0] first_row;
    logic [rro_pkg::RowBits-1:0] second_row;
    logic overflow;
  } verdict_t;
endpackage

// ===== bench/tb_top.sv =====
// Testbench top: drives rectangle sets, predicts overlap verdicts, checks results.
`timescale 1ns / 1ps
module tb_top;
  localparam int Cb = rro_pkg::CoordBits;
  localparam int MaxN = rro_pkg::MaxRects;
  typedef logic [Cb-1:0] coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rro_pkg::CfgIdxBits-1:0] cfg_index = rro_pkg::RegThetaStep;
  logic [Cb-1:0] cfg_data = '0;

  rro_in_if req ();
  rro_out_if res ();

  rect_region_overlap_check dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  tb_rro_types::rect_req_t pending_rects[$];
  tb_rro_types::verdict_t expected_verdicts[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  bit in_fire = 1'b0;

  // predictor state
  coord_t set_tl[MaxN], set_tu[MaxN], set_pl[MaxN], set_pu[MaxN];
  int set_count = 0;
  bit set_overflow = 1'b0;
  coord_t cur_theta_nudge = '0, cur_phi_nudge = '0;

  function automatic bit rect_precedes(int a, int b);
    if (set_tl[a] != set_tl[b]) return set_tl[a] < set_tl[b];
    if (set_tu[a] != set_tu[b]) return set_tu[a] < set_tu[b];
    if (set_pl[a] != set_pl[b]) return set_pl[a] < set_pl[b];
    if (set_pu[a] != set_pu[b]) return set_pu[a] < set_pu[b];
    return a < b;
  endfunction

  function automatic tb_rro_types::verdict_t judge_set();
    int order[MaxN];
    int j, k, a, b, cur;
    logic [Cb:0] sum;
    bit fail;
    tb_rro_types::verdict_t v;
    for (int i = 0; i < set_count; i++) begin
      cur = i;
      j = i;
      while (j > 0 && rect_precedes(cur, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    v = '{pass: 1'b1, first_row: '0, second_row: '0, overflow: set_overflow};
    for (j = 0; j + 1 < set_count; j++) begin
      a = order[j];
      for (k = j + 1; k < set_count; k++) begin
        b = order[k];
        fail = 1'b0;
        if (set_tu[a] == set_tl[b]) begin
          sum = {1'b0, set_tl[b]} + {1'b0, cur_theta_nudge};
          if (set_pu[a] >= set_pl[b] && sum > {1'b0, set_tu[b]}) fail = 1'b1;
        end else if (set_tu[a] > set_tl[b]) begin
          if (set_pu[a] == set_pl[b]) begin
            sum = {1'b0, set_pl[b]} + {1'b0, cur_phi_nudge};
            if (sum > {1'b0, set_pu[b]}) fail = 1'b1;
          end else if (set_pu[a] > set_pl[b]) begin
            fail = 1'b1;
          end
        end else begin
          break;
        end
        if (fail) begin
          v.pass = 1'b0;
          v.first_row = a[rro_pkg::RowBits-1:0];
          v.second_row = b[rro_pkg::RowBits-1:0];
          return v;
        end
      end
    end
    return v;
  endfunction

  task automatic absorb_rect(tb_rro_types::rect_req_t r);
    if (set_count < MaxN) begin
      set_tl[set_count] = r.tl;
      set_tu[set_count] = r.tu;
      set_pl[set_count] = r.pl;
      set_pu[set_count] = r.pu;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (r.last) begin
      expected_verdicts.push_back(judge_set());
      set_count = 0;
      set_overflow = 1'b0;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.theta_lower <= '0;
      req.theta_upper <= '0;
      req.phi_lower <= '0;
      req.phi_upper <= '0;
      req.last_rect <= 1'b0;
    end else if (!req.valid || in_fire) begin
      if (pending_rects.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req.valid <= 1'b1;
        {req.theta_lower, req.theta_upper, req.phi_lower, req.phi_upper, req.last_rect}
          <= pending_rects.pop_front();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // request acceptance and result check
  always @(posedge clk) begin
    tb_rro_types::verdict_t got, want;
    in_fire <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready)
      absorb_rect('{req.theta_lower, req.theta_upper, req.phi_lower, req.phi_upper,
                    req.last_rect});
    if (!rst && res.valid && res.ready) begin
      got = '{res.pass, res.first_row, res.second_row, res.overflow};
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // receiver ready, with a long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_off > 0) begin
      res.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic coord_t crd(int unsigned v);
    return coord_t'(v);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic queue_rect(coord_t tl, coord_t tu, coord_t pl, coord_t pu, bit last);
    pending_rects.push_back('{tl, tu, pl, pu, last});
  endtask

  // Mostly small grid-aligned sets so edges touch and overlap often.
  task automatic queue_random_set(int n);
    coord_t base, unit, tl, pl;
    base = coord_t'($urandom_range(1000));
    unit = coord_t'($urandom_range(1, 4) << $urandom_range(0, 16));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        queue_rect(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i == n - 1);
      end else begin
        tl = coord_t'(base + unit * $urandom_range(6));
        pl = coord_t'(base + unit * $urandom_range(6));
        queue_rect(tl, coord_t'(tl + unit * $urandom_range(3)),
                   pl, coord_t'(pl + unit * $urandom_range(3)), i == n - 1);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_rects.size() > 0 || req.valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [rro_pkg::CfgIdxBits-1:0] idx, coord_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rro_pkg::RegThetaStep) cur_theta_nudge = val;
    else if (idx == rro_pkg::RegPhiStep) cur_phi_nudge = val;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: steps at reset value zero
    queue_rect(crd(5), crd(10), crd(5), crd(10), 1'b1);     // single rectangle
    queue_rect(crd(0), crd(10), crd(0), crd(10), 1'b0);     // edge share, zero step
    queue_rect(crd(10), crd(20), crd(0), crd(10), 1'b1);
    queue_rect(crd(0), crd(10), crd(0), crd(10), 1'b0);     // overlap
    queue_rect(crd(5), crd(15), crd(5), crd(15), 1'b1);
    queue_rect('1, '1, '1, '1, 1'b0);                       // extremes and inverted
    queue_rect('0, '0, '0, '0, 1'b0);
    queue_rect(crd(30), crd(20), crd(40), crd(10), 1'b1);
    wait_drained();

    write_reg(rro_pkg::RegThetaStep, '1);
    write_reg(rro_pkg::RegPhiStep, '1);
    queue_rect(crd(0), crd(10), crd(0), crd(10), 1'b0);     // theta edge nudge inverts
    queue_rect(crd(10), crd(20), crd(0), crd(10), 1'b1);
    queue_rect(crd(0), crd(10), crd(0), crd(10), 1'b0);     // phi edge nudge inverts
    queue_rect(crd(5), crd(15), crd(10), crd(20), 1'b1);
    queue_rect(crd(0), crd(10), crd(0), crd(10), 1'b0);     // disjoint in theta: scan stops
    queue_rect(crd(20), crd(30), crd(0), crd(10), 1'b1);
    queue_rect('1, '1, '0, '0, 1'b0);                       // sum must not wrap
    queue_rect('1, '1, '0, '1, 1'b1);
    wait_drained();

    write_reg(rro_pkg::RegThetaStep, crd(3));
    write_reg(rro_pkg::RegPhiStep, crd(0));
    for (int i = 0; i < MaxN + 3; i++)                      // capacity overflow
      queue_rect(coord_t'(i * 100), coord_t'(i * 100 + 50), crd(0), crd(5), i == MaxN + 2);
    wait_drained();

    // long receiver hold-off while a stream of sets keeps coming
    hold_off = 400;
    for (int s = 0; s < 20; s++) queue_random_set($urandom_range(1, 4));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_reg(rro_pkg::RegThetaStep,
                ph == 0 ? coord_t'(0) : coord_t'($urandom_range(0, 1 << ph*5)));
      write_reg(rro_pkg::RegPhiStep, ph == 3 ? '1 : coord_t'($urandom_range(0, 1 << ph*5)));
      for (int s = 0; s < 45; s++) begin
        int n;
        n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        queue_random_set(n);
      end
      wait_drained();
    end

    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #(12ns * 2000000);
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/rro_pkg.sv
sv/rro_if.sv
sv/rro_ram.sv
sv/rro_datapath.sv
sv/rro_ctrl.sv
sv/rect_region_overlap_check.sv
bench/tb_rro_if.sv
bench/tb_top.sv
